FILE: sv/fdm_pkg.sv
// ----------------------------------------------------------------------------
// fdm_pkg
// Shared constants and types for the feedback delay mix block: default
// parameter values, register indexes, register reset values and the
// controller states.
// ----------------------------------------------------------------------------
package fdm_pkg;

    localparam int DEF_LINE_DEPTH  = 32768;
    localparam int DEF_SAMPLE_BITS = 24;
    localparam int DEF_COEF_BITS   = 16;

    localparam int CFG_BITS     = 16;
    localparam int CFG_IDX_BITS = 2;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_DELAY_LENGTH,
        REG_FEEDBACK_AMOUNT,
        REG_WET_MIX,
        REG_OUTPUT_GAIN
    } fdm_reg_t;

    localparam logic [CFG_BITS-1:0] RST_DELAY_LENGTH    = 16'd9600;
    localparam logic [CFG_BITS-1:0] RST_FEEDBACK_AMOUNT = 16'd11469;
    localparam logic [CFG_BITS-1:0] RST_WET_MIX         = 16'd16384;
    localparam logic [CFG_BITS-1:0] RST_OUTPUT_GAIN     = 16'd32768;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MUL,
        ST_WB,
        ST_SUM,
        ST_GAIN
    } fdm_state_t;

endpackage

FILE: sv/feedback_delay_mix.sv
// ----------------------------------------------------------------------------
// feedback_delay_mix
// Stereo feedback comb delay with dry/wet mix and output gain.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one stereo frame a beat.
//   Output channel (out_valid / out_stall) returns one processed frame for
//   every input beat, in order.
//   Path: an accepted frame passes the MUL, WB, SUM and GAIN states; out_valid
//   rises once the gain result is loaded into the free output register.
//   One frame at a time: in_stall stays high from accept until the controller
//   is back in idle, set by the one-port line memories (read at accept, write
//   back in the WB state) and the three multiply stages of the mix and gain path.
//   Reset: the line memories are swept to zero, one entry a cycle, over all
//   LINE_DEPTH entries (32768 by default); in_stall stays high during the
//   sweep. Configuration writes are taken at any time, also during it.
//   Receiver stall: the finished frame holds in the output register; the
//   next frame is still taken and processed and waits in the last stage
//   until the output register frees up.
//   Configuration: cfg_write with cfg_index and cfg_data; write only while
//   no frame is in flight.
// ----------------------------------------------------------------------------
module feedback_delay_mix #(
    parameter int LINE_DEPTH  = fdm_pkg::DEF_LINE_DEPTH,
    parameter int SAMPLE_BITS = fdm_pkg::DEF_SAMPLE_BITS,
    parameter int COEF_BITS   = fdm_pkg::DEF_COEF_BITS
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [fdm_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [fdm_pkg::CFG_BITS-1:0]         cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic signed [SAMPLE_BITS-1:0]        left_in,
    input  logic signed [SAMPLE_BITS-1:0]        right_in,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [SAMPLE_BITS-1:0]        left_out,
    output logic signed [SAMPLE_BITS-1:0]        right_out
);
    import fdm_pkg::*;

    localparam int SW   = SAMPLE_BITS;
    localparam int CB   = COEF_BITS;
    localparam int SH   = COEF_BITS - 1;
    localparam int PW   = $clog2(LINE_DEPTH);
    localparam int LENW = (PW + 1 > CFG_BITS) ? PW + 1 : CFG_BITS;
    localparam int CLW  = ((CB > CFG_BITS) ? CB : CFG_BITS) + 1;

    localparam logic [CB-1:0]  COEF_ONE = {1'b1, {SH{1'b0}}};
    localparam logic [CLW-1:0] COEF_ONE_W = CLW'(COEF_ONE);
    localparam logic [PW-1:0]  CLR_LAST = PW'(LINE_DEPTH - 1);
    localparam logic signed [SW-1:0] SMAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0] SMIN = {1'b1, {(SW-1){1'b0}}};

    fdm_state_t state_reg, state_next;

    logic [CFG_BITS-1:0] delay_length_reg;
    logic [CFG_BITS-1:0] feedback_reg;
    logic [CFG_BITS-1:0] wet_mix_reg;
    logic [CFG_BITS-1:0] gain_reg;

    logic [PW-1:0] pos_reg, pos_next;
    logic [PW-1:0] clr_reg;
    logic          out_valid_reg;

    logic [LENW-1:0] len_w;
    logic [PW:0]     len;
    logic [PW-1:0]   pos_eff;
    logic [PW:0]     pos_inc;

    logic [CLW-1:0] fb_w, mx_w, gn_w;
    logic [CB-1:0]  fb_c, mx_c, gn_c, inv_mx_c;

    logic          in_take;
    logic          mem_we;
    logic          mem_clr;
    logic [PW-1:0] mem_addr;
    logic          out_load;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_length_reg <= RST_DELAY_LENGTH;
            feedback_reg     <= RST_FEEDBACK_AMOUNT;
            wet_mix_reg      <= RST_WET_MIX;
            gain_reg         <= RST_OUTPUT_GAIN;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_DELAY_LENGTH:    delay_length_reg <= cfg_data;
                REG_FEEDBACK_AMOUNT: feedback_reg     <= cfg_data;
                REG_WET_MIX:         wet_mix_reg      <= cfg_data;
                REG_OUTPUT_GAIN:     gain_reg         <= cfg_data;
                default:             ;
            endcase
        end
    end

    // clamp length, read position and coefficients; form the dry mix coefficient
    always_comb
    begin
        if (delay_length_reg == '0)
            len_w = LENW'(1);
        else if (LENW'(delay_length_reg) > LENW'(LINE_DEPTH))
            len_w = LENW'(LINE_DEPTH);
        else
            len_w = LENW'(delay_length_reg);
        len     = len_w[PW:0];
        pos_eff = ({1'b0, pos_reg} >= len) ? '0 : pos_reg;
        pos_inc = {1'b0, pos_reg} + (PW+1)'(1);

        fb_w = (CLW'(feedback_reg) > COEF_ONE_W) ? COEF_ONE_W : CLW'(feedback_reg);
        mx_w = (CLW'(wet_mix_reg)  > COEF_ONE_W) ? COEF_ONE_W : CLW'(wet_mix_reg);
        gn_w = (CLW'(gain_reg)     > COEF_ONE_W) ? COEF_ONE_W : CLW'(gain_reg);
        fb_c     = fb_w[CB-1:0];
        mx_c     = mx_w[CB-1:0];
        gn_c     = gn_w[CB-1:0];
        inv_mx_c = COEF_ONE - mx_c;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: if (clr_reg == CLR_LAST) state_next = ST_IDLE;
            ST_IDLE:  if (in_valid) state_next = ST_MUL;
            ST_MUL:   state_next = ST_WB;
            ST_WB:    state_next = ST_SUM;
            ST_SUM:   state_next = ST_GAIN;
            ST_GAIN:  if (!out_valid_reg || !out_stall) state_next = ST_IDLE;
            default:  state_next = ST_CLEAR;
        endcase
    end

    // controller outputs
    always_comb
    begin
        in_stall = 1'b1;
        mem_we   = 1'b0;
        mem_clr  = 1'b0;
        mem_addr = pos_reg;
        out_load = 1'b0;
        pos_next = pos_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                mem_we   = 1'b1;
                mem_clr  = 1'b1;
                mem_addr = clr_reg;
            end
            ST_IDLE:
            begin
                in_stall = 1'b0;
                mem_addr = pos_eff;
                pos_next = pos_eff;
            end
            ST_WB:
            begin
                mem_we   = 1'b1;
                pos_next = (pos_inc >= len) ? '0 : pos_inc[PW-1:0];
            end
            ST_GAIN:  out_load = !out_valid_reg || !out_stall;
            default:  ;
        endcase
    end

    assign in_take = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
                clr_reg <= clr_reg + PW'(1);
            if (in_take || state_reg == ST_WB)
                pos_reg <= pos_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;

    logic signed [SW-1:0] dry_in  [2];
    logic signed [SW-1:0] out_dat [2];

    assign dry_in[0] = left_in;
    assign dry_in[1] = right_in;
    assign left_out  = out_dat[0];
    assign right_out = out_dat[1];

    for (genvar ch = 0; ch < 2; ch++)
    begin : g_lane
        logic [SW-1:0]        line_mem [LINE_DEPTH];
        logic [SW-1:0]        line_rd_reg;
        logic signed [SW-1:0] dry_reg;
        logic signed [SW-1:0] delayed_reg, delayed_next;
        logic signed [SW-1:0] dry_part_reg, dry_part_next;
        logic signed [SW-1:0] wet_part_reg, wet_part_next;
        logic signed [SW:0]   mixed_reg, mixed_next;
        logic signed [SW-1:0] out_reg, out_next;
        logic signed [SW-1:0] wb_val;
        logic [SW-1:0]        mem_wdata;
        logic signed [SW+CB:0]   p_fb, p_dry, p_wet, s_fb, s_dry, s_wet;
        logic signed [SW+CB+1:0] p_gn, s_gn;
        logic signed [SW:0]      wb_sum, gained;

        always_comb
        begin
            p_fb  = $signed(line_rd_reg) * $signed({1'b0, fb_c});
            s_fb  = p_fb >>> SH;
            delayed_next = s_fb[SW-1:0];

            p_dry = dry_reg * $signed({1'b0, inv_mx_c});
            s_dry = p_dry >>> SH;
            dry_part_next = s_dry[SW-1:0];

            p_wet = delayed_reg * $signed({1'b0, mx_c});
            s_wet = p_wet >>> SH;
            wet_part_next = s_wet[SW-1:0];

            mixed_next = (SW+1)'(dry_part_reg) + (SW+1)'(wet_part_reg);

            p_gn   = mixed_reg * $signed({1'b0, gn_c});
            s_gn   = p_gn >>> SH;
            gained = s_gn[SW:0];
            if (gained[SW] != gained[SW-1])
                out_next = gained[SW] ? SMIN : SMAX;
            else
                out_next = gained[SW-1:0];

            wb_sum = (SW+1)'(dry_reg) + (SW+1)'(delayed_reg);
            if (wb_sum[SW] != wb_sum[SW-1])
                wb_val = wb_sum[SW] ? SMIN : SMAX;
            else
                wb_val = wb_sum[SW-1:0];
            mem_wdata = mem_clr ? '0 : wb_val;
        end

        always_ff @(posedge clk)
        begin
            if (mem_we)
                line_mem[mem_addr] <= mem_wdata;
            line_rd_reg <= line_mem[mem_addr];
        end

        always_ff @(posedge clk)
        begin
            if (in_take)
                dry_reg <= dry_in[ch];
            if (state_reg == ST_MUL)
            begin
                delayed_reg  <= delayed_next;
                dry_part_reg <= dry_part_next;
            end
            if (state_reg == ST_WB)
                wet_part_reg <= wet_part_next;
            if (state_reg == ST_SUM)
                mixed_reg <= mixed_next;
            if (out_load)
                out_reg <= out_next;
        end

        assign out_dat[ch] = out_reg;
    end

    a_take_to_gain: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |-> ##4 (state_reg == ST_GAIN))
        else $error("accepted frame did not reach the gain stage");

    a_wb_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WB) |-> ({1'b0, pos_reg} < len))
        else $error("write-back position beyond the delay length");

    a_out_from_gain: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> ($past(state_reg) == ST_GAIN))
        else $error("output beat without a finished frame");

    a_no_take_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |=> !(state_reg == ST_MUL))
        else $error("frame processed during the clearing sweep");

endmodule

FILE: tb/feedback_delay_mix_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// feedback_delay_mix_tb
// Self-checking bench for the stereo feedback comb delay. A directed set of
// frames covers the sample extremes and the register corner cases: zero
// length, oversized length, a length cut below the current position, and
// coefficients above unity. Random phases follow, each with a fresh register
// setting, most of them with short lines so that the feedback path gets
// exercised. A built-in model of both delay lines predicts every output
// frame. The sender runs in bursts and the receiver stalls on its own
// changing pattern.
// ----------------------------------------------------------------------------
module feedback_delay_mix_tb;

    import fdm_pkg::*;

    localparam int LINE_DEPTH = DEF_LINE_DEPTH;
    localparam int COEF_SHIFT = DEF_COEF_BITS - 1;
    localparam longint Q15_ONE = 64'sd1 <<< COEF_SHIFT;
    localparam longint SMP_HI = (64'sd1 <<< (DEF_SAMPLE_BITS - 1)) - 1;
    localparam longint SMP_LO = -(64'sd1 <<< (DEF_SAMPLE_BITS - 1));
    localparam logic signed [23:0] SMP_MAX = 24'sh7fffff;
    localparam logic signed [23:0] SMP_MIN = 24'sh800000;

    typedef struct packed {
        logic signed [23:0] left;
        logic signed [23:0] right;
    } stereo_t;

    typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          cfg_write = 1'b0;
    logic [CFG_IDX_BITS-1:0]       cfg_index = '0;
    logic [CFG_BITS-1:0]           cfg_data = '0;
    logic                          in_valid = 1'b0;
    logic                          in_stall;
    logic signed [23:0]            left_in = '0;
    logic signed [23:0]            right_in = '0;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    logic signed [23:0]            left_out;
    logic signed [23:0]            right_out;

    stereo_t     dry_q[$];
    stereo_t     mixed_q[$];
    int          frames_sent = 0;
    int          frames_mixed = 0;
    int          err_cnt = 0;

    int          burst_left = 0;
    int          gap_left = 0;
    stall_mode_t stall_mode = STALL_NONE;
    int          stall_hold = 0;
    int          stall_tick = 0;

    logic [CFG_BITS-1:0] dly_len = RST_DELAY_LENGTH;
    logic [CFG_BITS-1:0] fb_coef = RST_FEEDBACK_AMOUNT;
    logic [CFG_BITS-1:0] mix_coef = RST_WET_MIX;
    logic [CFG_BITS-1:0] gain_coef = RST_OUTPUT_GAIN;
    int                  line_mem [2][LINE_DEPTH];
    int                  line_pos = 0;

    feedback_delay_mix dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .left_in   (left_in),
        .right_in  (right_in),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .left_out  (left_out),
        .right_out (right_out)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic longint clip24(longint x);
        if (x > SMP_HI)
            return SMP_HI;
        if (x < SMP_LO)
            return SMP_LO;
        return x;
    endfunction

    function automatic longint unity_clip(logic [CFG_BITS-1:0] c);
        return (longint'(c) > Q15_ONE) ? Q15_ONE : longint'(c);
    endfunction

    function automatic logic signed [23:0] comb_channel(int ch, logic signed [23:0] dry);
        longint d;
        longint fb;
        longint mx;
        longint gn;
        longint delayed;
        longint mixed;
        d = longint'(dry);
        fb = unity_clip(fb_coef);
        mx = unity_clip(mix_coef);
        gn = unity_clip(gain_coef);
        delayed = (longint'(line_mem[ch][line_pos]) * fb) >>> COEF_SHIFT;
        line_mem[ch][line_pos] = int'(clip24(d + delayed));
        mixed = ((d * (Q15_ONE - mx)) >>> COEF_SHIFT) + ((delayed * mx) >>> COEF_SHIFT);
        return 24'(clip24((mixed * gn) >>> COEF_SHIFT));
    endfunction

    function automatic stereo_t comb_frame(logic signed [23:0] l, logic signed [23:0] r);
        int      len;
        stereo_t f;
        len = int'(dly_len);
        if (len == 0)
            len = 1;
        if (len > LINE_DEPTH)
            len = LINE_DEPTH;
        if (line_pos >= len)
            line_pos = 0;
        f.left = comb_channel(0, l);
        f.right = comb_channel(1, r);
        line_pos = (line_pos + 1 >= len) ? 0 : line_pos + 1;
        return f;
    endfunction

    function automatic logic signed [23:0] rand_sample();
        case ($urandom_range(0, 9))
            0: return SMP_MAX;
            1: return SMP_MIN;
            2: return 24'($signed($urandom_range(0, 1023)) - 512);
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_BITS-1:0] pick_length();
        case ($urandom_range(0, 11))
            0: return 16'd0;
            1: return 16'd1;
            2: return 16'hffff;
            3: return 16'(LINE_DEPTH);
            4, 5, 6: return 16'($urandom_range(2, 8));
            7, 8, 9: return 16'($urandom_range(9, 64));
            default: return 16'($urandom_range(65, 40000));
        endcase
    endfunction

    function automatic logic [CFG_BITS-1:0] pick_coef();
        case ($urandom_range(0, 7))
            0: return 16'd0;
            1: return 16'(Q15_ONE);
            2: return 16'($urandom_range(32769, 65535));
            default: return 16'($urandom_range(0, 32768));
        endcase
    endfunction

    task automatic send_frame(logic signed [23:0] l, logic signed [23:0] r);
        stereo_t f;
        f.left = l;
        f.right = r;
        dry_q = {dry_q, f};
        frames_sent++;
    endtask

    task automatic wait_drained();
        wait (frames_mixed == frames_sent);
    endtask

    task automatic set_config(logic [CFG_BITS-1:0] len, logic [CFG_BITS-1:0] fb,
                              logic [CFG_BITS-1:0] mix, logic [CFG_BITS-1:0] gain);
        logic [CFG_BITS-1:0] vals [4];
        vals = '{len, fb, mix, gain};
        for (int i = 0; i < 4; i++)
        begin
            @(posedge clk);
            cfg_write <= 1'b1;
            cfg_index <= fdm_reg_t'(i);
            cfg_data <= vals[i];
        end
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    // sender: hold the payload until the beat is taken, idle in random gaps
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                void'(dry_q.pop_front());
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0 || dry_q.size() == 0)
                begin
                    in_valid <= 1'b0;
                    if (gap_left > 0)
                        gap_left--;
                end
                else
                begin
                    in_valid <= 1'b1;
                    left_in <= dry_q[0].left;
                    right_in <= dry_q[0].right;
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(0, 40);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
                    end
                end
            end
        end
    end

    // receiver: switch to a random stall pattern when the random hold runs out
    always @(posedge clk)
    begin
        if (stall_hold == 0)
        begin
            stall_mode = stall_mode_t'($urandom_range(0, 3));
            stall_hold = $urandom_range(20, 300);
        end
        else
            stall_hold--;
        case (stall_mode)
            STALL_NONE:  out_stall <= 1'b0;
            STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
            default:     out_stall <= ((stall_tick % 7) < 3);
        endcase
        stall_tick++;
    end

    always @(posedge clk)
    begin : monitor
        stereo_t want;
        if (rst_n)
        begin
            if (cfg_write)
            begin
                case (fdm_reg_t'(cfg_index))
                    REG_DELAY_LENGTH:    dly_len = cfg_data;
                    REG_FEEDBACK_AMOUNT: fb_coef = cfg_data;
                    REG_WET_MIX:         mix_coef = cfg_data;
                    REG_OUTPUT_GAIN:     gain_coef = cfg_data;
                    default:             ;
                endcase
            end
            if (in_valid && !in_stall)
                mixed_q = {mixed_q, comb_frame(left_in, right_in)};
            if (out_valid && !out_stall)
            begin
                if (mixed_q.size() == 0)
                begin
                    $display("%0t: output beat with no frame pending (%0d, %0d)",
                             $time, left_out, right_out);
                    err_cnt++;
                end
                else
                begin
                    want = mixed_q.pop_front();
                    if (left_out !== want.left)
                    begin
                        $display("%0t: left_out expected %0d, got %0d",
                                 $time, want.left, left_out);
                        err_cnt++;
                    end
                    if (right_out !== want.right)
                    begin
                        $display("%0t: right_out expected %0d, got %0d",
                                 $time, want.right, right_out);
                        err_cnt++;
                    end
                    frames_mixed++;
                end
            end
        end
    end

    initial
    begin
        int n_rand;
        int n_items;
        n_rand = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        send_frame(24'sd0, 24'sd0);
        send_frame(SMP_MAX, SMP_MAX);
        send_frame(SMP_MIN, SMP_MIN);
        send_frame(-24'sd1, 24'sd1);
        wait_drained();

        // cut the line below the current position, full feedback
        set_config(16'd3, 16'(Q15_ONE), 16'd16384, 16'(Q15_ONE));
        repeat (4) send_frame(SMP_MAX, SMP_MIN);
        repeat (2) send_frame(SMP_MIN, SMP_MAX);
        wait_drained();

        // zero length, every coefficient above unity
        set_config(16'd0, 16'hffff, 16'hffff, 16'hffff);
        send_frame(SMP_MIN, SMP_MAX);
        send_frame(SMP_MIN, SMP_MAX);
        send_frame(24'sd12345, -24'sd12345);
        wait_drained();

        // oversized length, no feedback, fully dry
        set_config(16'hffff, 16'd0, 16'd0, 16'(Q15_ONE));
        send_frame(SMP_MAX, SMP_MIN);
        send_frame(24'sd1, -24'sd1);
        wait_drained();

        // fully wet at half gain
        set_config(16'd10, 16'(Q15_ONE), 16'(Q15_ONE), 16'd16384);
        repeat (7) send_frame(rand_sample(), rand_sample());
        wait_drained();

        while (n_rand < 1030)
        begin
            set_config(pick_length(), pick_coef(), pick_coef(), pick_coef());
            n_items = $urandom_range(40, 120);
            repeat (n_items) send_frame(rand_sample(), rand_sample());
            n_rand += n_items;
            wait_drained();
        end

        repeat (20) @(posedge clk);
        if (err_cnt == 0 && mixed_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

FILE: sim.f
sv/fdm_pkg.sv
sv/feedback_delay_mix.sv
tb/feedback_delay_mix_tb.sv
